>>> hw/rtl/esc_pkg.sv
package esc_pkg;

  // Sample kinds
  localparam logic [1:0] CMD_TEMP  = 2'd0;
  localparam logic [1:0] CMD_PRESS = 2'd1;
  localparam logic [1:0] CMD_HUM   = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_TEMP       = 3'd0,
    CFG_PRESS_LOW  = 3'd1,
    CFG_PRESS_HIGH = 3'd2,
    CFG_PRESS_HUM  = 3'd3,
    CFG_HUM        = 3'd4
  } cfg_idx_t;

  localparam int          NUM_TMP  = 6;
  localparam logic [31:0] HUM_MAX  = 32'd419430400;

  // Micro-operations of the shared datapath
  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_SHL, OP_ASR, OP_ASR32, OP_MUL, OP_DIV,
    OP_FTW, OP_CHKZ, OP_OUT64, OP_OUT32, OP_OUTH
  } op_t;

  // Operand sources: scratch registers, item, state, calibration, constants
  typedef enum logic [5:0] {
    S_R0, S_R1, S_R2, S_R3, S_R4, S_R5,
    S_RAW, S_RAWH, S_FT,
    S_T1, S_T2, S_T3,
    S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
    S_H1, S_H2, S_H3, S_H4, S_H5, S_H6,
    S_K5, S_K128, S_K76800, S_K16384, S_K32768, S_K2097152, S_K8192,
    S_K128000, S_K2P47, S_K1048576, S_K3125, S_ZERO
  } src_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_DIV  = 4'b1000
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] dst;
    src_t       a;
    src_t       b;
    logic [5:0] sh;
  } uinst_t;

  localparam int PC_W = 7;

  localparam logic [PC_W-1:0] PC_TEMP  = 7'd0;
  localparam logic [PC_W-1:0] PC_HUM   = 7'd17;
  localparam logic [PC_W-1:0] PC_PRESS = 7'd44;
  localparam logic [PC_W-1:0] PC_NONE  = 7'd78;

  function automatic uinst_t mk(op_t op, logic [2:0] dst, src_t a, src_t b, logic [5:0] sh);
    uinst_t u;
    u.op  = op;
    u.dst = dst;
    u.a   = a;
    u.b   = b;
    u.sh  = sh;
    return u;
  endfunction

  function automatic logic [PC_W-1:0] entry_pc(logic [1:0] cmd);
    logic [PC_W-1:0] pc;
    case (cmd)
      CMD_TEMP:  pc = PC_TEMP;
      CMD_PRESS: pc = PC_PRESS;
      CMD_HUM:   pc = PC_HUM;
      default:   pc = PC_NONE;
    endcase
    return pc;
  endfunction

  // Microprogram: temperature, humidity, pressure, unused kind
  function automatic uinst_t ucode(logic [PC_W-1:0] pc);
    uinst_t u;
    case (pc)
      // temperature
      7'd0:  u = mk(OP_ASR,   3'd0, S_RAW,  S_ZERO, 6'd3);
      7'd1:  u = mk(OP_SHL,   3'd1, S_T1,   S_ZERO, 6'd1);
      7'd2:  u = mk(OP_SUB,   3'd0, S_R0,   S_R1,   6'd0);
      7'd3:  u = mk(OP_MUL,   3'd0, S_R0,   S_T2,   6'd0);
      7'd4:  u = mk(OP_ASR32, 3'd0, S_R0,   S_ZERO, 6'd11);
      7'd5:  u = mk(OP_ASR,   3'd1, S_RAW,  S_ZERO, 6'd4);
      7'd6:  u = mk(OP_SUB,   3'd1, S_R1,   S_T1,   6'd0);
      7'd7:  u = mk(OP_MUL,   3'd1, S_R1,   S_R1,   6'd0);
      7'd8:  u = mk(OP_ASR32, 3'd1, S_R1,   S_ZERO, 6'd12);
      7'd9:  u = mk(OP_MUL,   3'd1, S_R1,   S_T3,   6'd0);
      7'd10: u = mk(OP_ASR32, 3'd1, S_R1,   S_ZERO, 6'd14);
      7'd11: u = mk(OP_ADD,   3'd0, S_R0,   S_R1,   6'd0);
      7'd12: u = mk(OP_FTW,   3'd0, S_R0,   S_ZERO, 6'd0);
      7'd13: u = mk(OP_MUL,   3'd1, S_R0,   S_K5,   6'd0);
      7'd14: u = mk(OP_ADD,   3'd1, S_R1,   S_K128, 6'd0);
      7'd15: u = mk(OP_ASR32, 3'd1, S_R1,   S_ZERO, 6'd8);
      7'd16: u = mk(OP_OUT32, 3'd0, S_R1,   S_ZERO, 6'd0);
      // humidity
      7'd17: u = mk(OP_SUB,   3'd0, S_FT,   S_K76800, 6'd0);
      7'd18: u = mk(OP_SHL,   3'd1, S_RAWH, S_ZERO, 6'd14);
      7'd19: u = mk(OP_SHL,   3'd2, S_H4,   S_ZERO, 6'd20);
      7'd20: u = mk(OP_SUB,   3'd1, S_R1,   S_R2,   6'd0);
      7'd21: u = mk(OP_MUL,   3'd2, S_H5,   S_R0,   6'd0);
      7'd22: u = mk(OP_SUB,   3'd1, S_R1,   S_R2,   6'd0);
      7'd23: u = mk(OP_ADD,   3'd1, S_R1,   S_K16384, 6'd0);
      7'd24: u = mk(OP_ASR32, 3'd1, S_R1,   S_ZERO, 6'd15);
      7'd25: u = mk(OP_MUL,   3'd2, S_R0,   S_H6,   6'd0);
      7'd26: u = mk(OP_ASR32, 3'd2, S_R2,   S_ZERO, 6'd10);
      7'd27: u = mk(OP_MUL,   3'd3, S_R0,   S_H3,   6'd0);
      7'd28: u = mk(OP_ASR32, 3'd3, S_R3,   S_ZERO, 6'd11);
      7'd29: u = mk(OP_ADD,   3'd3, S_R3,   S_K32768, 6'd0);
      7'd30: u = mk(OP_MUL,   3'd2, S_R2,   S_R3,   6'd0);
      7'd31: u = mk(OP_ASR32, 3'd2, S_R2,   S_ZERO, 6'd10);
      7'd32: u = mk(OP_ADD,   3'd2, S_R2,   S_K2097152, 6'd0);
      7'd33: u = mk(OP_MUL,   3'd2, S_R2,   S_H2,   6'd0);
      7'd34: u = mk(OP_ADD,   3'd2, S_R2,   S_K8192, 6'd0);
      7'd35: u = mk(OP_ASR32, 3'd2, S_R2,   S_ZERO, 6'd14);
      7'd36: u = mk(OP_MUL,   3'd0, S_R1,   S_R2,   6'd0);
      7'd37: u = mk(OP_ASR32, 3'd1, S_R0,   S_ZERO, 6'd15);
      7'd38: u = mk(OP_MUL,   3'd1, S_R1,   S_R1,   6'd0);
      7'd39: u = mk(OP_ASR32, 3'd1, S_R1,   S_ZERO, 6'd7);
      7'd40: u = mk(OP_MUL,   3'd1, S_R1,   S_H1,   6'd0);
      7'd41: u = mk(OP_ASR32, 3'd1, S_R1,   S_ZERO, 6'd4);
      7'd42: u = mk(OP_SUB,   3'd0, S_R0,   S_R1,   6'd0);
      7'd43: u = mk(OP_OUTH,  3'd0, S_R0,   S_ZERO, 6'd0);
      // pressure
      7'd44: u = mk(OP_SUB,   3'd0, S_FT,   S_K128000, 6'd0);
      7'd45: u = mk(OP_MUL,   3'd1, S_R0,   S_R0,   6'd0);
      7'd46: u = mk(OP_MUL,   3'd2, S_R1,   S_P6,   6'd0);
      7'd47: u = mk(OP_MUL,   3'd3, S_R0,   S_P5,   6'd0);
      7'd48: u = mk(OP_SHL,   3'd3, S_R3,   S_ZERO, 6'd17);
      7'd49: u = mk(OP_ADD,   3'd2, S_R2,   S_R3,   6'd0);
      7'd50: u = mk(OP_SHL,   3'd3, S_P4,   S_ZERO, 6'd35);
      7'd51: u = mk(OP_ADD,   3'd2, S_R2,   S_R3,   6'd0);
      7'd52: u = mk(OP_MUL,   3'd3, S_R1,   S_P3,   6'd0);
      7'd53: u = mk(OP_ASR,   3'd3, S_R3,   S_ZERO, 6'd8);
      7'd54: u = mk(OP_MUL,   3'd4, S_R0,   S_P2,   6'd0);
      7'd55: u = mk(OP_SHL,   3'd4, S_R4,   S_ZERO, 6'd12);
      7'd56: u = mk(OP_ADD,   3'd3, S_R3,   S_R4,   6'd0);
      7'd57: u = mk(OP_ADD,   3'd3, S_R3,   S_K2P47, 6'd0);
      7'd58: u = mk(OP_MUL,   3'd3, S_R3,   S_P1,   6'd0);
      7'd59: u = mk(OP_ASR,   3'd3, S_R3,   S_ZERO, 6'd33);
      7'd60: u = mk(OP_CHKZ,  3'd0, S_R3,   S_ZERO, 6'd0);
      7'd61: u = mk(OP_SUB,   3'd4, S_K1048576, S_RAW, 6'd0);
      7'd62: u = mk(OP_SHL,   3'd4, S_R4,   S_ZERO, 6'd31);
      7'd63: u = mk(OP_SUB,   3'd4, S_R4,   S_R2,   6'd0);
      7'd64: u = mk(OP_MUL,   3'd4, S_R4,   S_K3125, 6'd0);
      7'd65: u = mk(OP_DIV,   3'd4, S_R4,   S_R3,   6'd0);
      7'd66: u = mk(OP_ASR,   3'd5, S_R4,   S_ZERO, 6'd13);
      7'd67: u = mk(OP_MUL,   3'd0, S_P9,   S_R5,   6'd0);
      7'd68: u = mk(OP_MUL,   3'd0, S_R0,   S_R5,   6'd0);
      7'd69: u = mk(OP_ASR,   3'd0, S_R0,   S_ZERO, 6'd25);
      7'd70: u = mk(OP_MUL,   3'd1, S_P8,   S_R4,   6'd0);
      7'd71: u = mk(OP_ASR,   3'd1, S_R1,   S_ZERO, 6'd19);
      7'd72: u = mk(OP_ADD,   3'd4, S_R4,   S_R0,   6'd0);
      7'd73: u = mk(OP_ADD,   3'd4, S_R4,   S_R1,   6'd0);
      7'd74: u = mk(OP_ASR,   3'd4, S_R4,   S_ZERO, 6'd8);
      7'd75: u = mk(OP_SHL,   3'd1, S_P7,   S_ZERO, 6'd4);
      7'd76: u = mk(OP_ADD,   3'd4, S_R4,   S_R1,   6'd0);
      7'd77: u = mk(OP_OUT64, 3'd0, S_R4,   S_ZERO, 6'd0);
      // unused kind and anything unreachable
      default: u = mk(OP_OUT64, 3'd0, S_ZERO, S_ZERO, 6'd0);
    endcase
    return u;
  endfunction

endpackage

>>> hw/rtl/esc_if.sv
interface esc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [19:0] raw_sample;

  modport source (output valid, cmd, raw_sample, input ready);
  modport sink   (input valid, cmd, raw_sample, output ready);
endinterface

interface esc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [32:0] value;
  logic               status;

  modport source (output valid, kind, value, status, input ready);
  modport sink   (input valid, kind, value, status, output ready);
endinterface

>>> hw/rtl/env_sensor_compensation_unit.sv
// Channel | Dir | Beat payload                  | Handshake
// in_ch   | in  | cmd[1:0], raw_sample[19:0]    | valid/ready
// out_ch  | out | kind[1:0], value[32:0], status | valid/ready
// cfg_*   | in  | cfg_addr[2:0], cfg_wdata[63:0] | cfg_we, no wait
//
// One item at a time through a microcoded sequencer around a shared
// 32x32 multiplier, a 64-bit adder/shifter and a bit-serial divider.
// Every 64-bit product goes through the one multiplier as partial products;
// pressure items also wait on the divider.
// in_ch.ready is high only when the sequencer is idle; a finished result waits
// in the output register while the next item is taken and worked on.
// Synchronous active-low reset clears calibration, fine temperature and control.
module env_sensor_compensation_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  esc_in_if.sink                in_ch,
  esc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  esc_pkg::cfg_idx_t     cfg_addr,
  input  logic [63:0]           cfg_wdata
);
  import esc_pkg::*;

  state_t          state_r;
  logic [PC_W-1:0] pc_r;
  logic [1:0]      cmd_r;
  logic [19:0]     raw_r;
  logic [31:0]     ft_r;
  logic [47:0]     temp_cal_r;
  logic [63:0]     press_lo_r;
  logic [63:0]     press_hi_r;
  logic [47:0]     press_hum_r;
  logic [31:0]     hum_cal_r;
  logic [63:0]     rf_r [NUM_TMP];
  logic [63:0]     ma_r, mb_r, prod_r, acc_r;
  logic [1:0]      mph_r;

  logic               out_valid_r;
  logic [1:0]         out_kind_r;
  logic signed [32:0] out_value_r;
  logic               out_status_r;

  uinst_t      ui;
  logic [63:0] va, vb, alu_res, sx_a;
  logic [31:0] mul_x, mul_y, hclamp;
  logic [63:0] div_q;
  logic        div_done, div_start, out_free, in_acc, out_load;

  function automatic logic [63:0] src_val(src_t s);
    logic [63:0] v;
    case (s)
      S_R0:       v = rf_r[0];
      S_R1:       v = rf_r[1];
      S_R2:       v = rf_r[2];
      S_R3:       v = rf_r[3];
      S_R4:       v = rf_r[4];
      S_R5:       v = rf_r[5];
      S_RAW:      v = {44'd0, raw_r};
      S_RAWH:     v = {48'd0, raw_r[15:0]};
      S_FT:       v = {{32{ft_r[31]}}, ft_r};
      S_T1:       v = {48'd0, temp_cal_r[15:0]};
      S_T2:       v = {{48{temp_cal_r[31]}}, temp_cal_r[31:16]};
      S_T3:       v = {{48{temp_cal_r[47]}}, temp_cal_r[47:32]};
      S_P1:       v = {48'd0, press_lo_r[15:0]};
      S_P2:       v = {{48{press_lo_r[31]}}, press_lo_r[31:16]};
      S_P3:       v = {{48{press_lo_r[47]}}, press_lo_r[47:32]};
      S_P4:       v = {{48{press_lo_r[63]}}, press_lo_r[63:48]};
      S_P5:       v = {{48{press_hi_r[15]}}, press_hi_r[15:0]};
      S_P6:       v = {{48{press_hi_r[31]}}, press_hi_r[31:16]};
      S_P7:       v = {{48{press_hi_r[47]}}, press_hi_r[47:32]};
      S_P8:       v = {{48{press_hi_r[63]}}, press_hi_r[63:48]};
      S_P9:       v = {{48{press_hum_r[15]}}, press_hum_r[15:0]};
      S_H1:       v = {56'd0, press_hum_r[23:16]};
      S_H2:       v = {{48{press_hum_r[39]}}, press_hum_r[39:24]};
      S_H3:       v = {56'd0, press_hum_r[47:40]};
      S_H4:       v = {{52{hum_cal_r[11]}}, hum_cal_r[11:0]};
      S_H5:       v = {{52{hum_cal_r[23]}}, hum_cal_r[23:12]};
      S_H6:       v = {{56{hum_cal_r[31]}}, hum_cal_r[31:24]};
      S_K5:       v = 64'd5;
      S_K128:     v = 64'd128;
      S_K76800:   v = 64'd76800;
      S_K16384:   v = 64'd16384;
      S_K32768:   v = 64'd32768;
      S_K2097152: v = 64'd2097152;
      S_K8192:    v = 64'd8192;
      S_K128000:  v = 64'd128000;
      S_K2P47:    v = 64'h0000_8000_0000_0000;
      S_K1048576: v = 64'd1048576;
      S_K3125:    v = 64'd3125;
      default:    v = 64'd0;
    endcase
    return v;
  endfunction

  // Decode the current micro-op and fetch operands
  assign ui   = ucode(pc_r);
  assign va   = src_val(ui.a);
  assign vb   = src_val(ui.b);
  assign sx_a = {{32{va[31]}}, va[31:0]};

  // Shared adder / shifter
  always_comb begin
    case (ui.op)
      OP_ADD:   alu_res = va + vb;
      OP_SUB:   alu_res = va - vb;
      OP_SHL:   alu_res = va << ui.sh;
      OP_ASR:   alu_res = $signed(va) >>> ui.sh;
      OP_ASR32: alu_res = $signed(sx_a) >>> ui.sh;
      default:  alu_res = va;
    endcase
  end

  // Humidity clamp to 0..100 %
  assign hclamp = va[31] ? 32'd0 : ((va[31:0] > HUM_MAX) ? HUM_MAX : va[31:0]);

  // Shared 32x32 multiplier: low*low, low*high, high*low partial products
  assign mul_x = (mph_r == 2'd2) ? ma_r[63:32] : ma_r[31:0];
  assign mul_y = (mph_r == 2'd1) ? mb_r[63:32] : mb_r[31:0];

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign div_start = (state_r == ST_EXEC) && (ui.op == OP_DIV);

  // A new result is loaded into the output register this cycle
  assign out_load  = (state_r == ST_EXEC) && out_free &&
                     ((ui.op inside {OP_OUT64, OP_OUT32, OP_OUTH}) ||
                      (ui.op == OP_CHKZ && va == 64'd0));

  esc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (va),
    .den   (vb),
    .done  (div_done),
    .quo   (div_q)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r  <= 48'd0;
      press_lo_r  <= 64'd0;
      press_hi_r  <= 64'd0;
      press_hum_r <= 48'd0;
      hum_cal_r   <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TEMP:       temp_cal_r  <= cfg_wdata[47:0];
        CFG_PRESS_LOW:  press_lo_r  <= cfg_wdata;
        CFG_PRESS_HIGH: press_hi_r  <= cfg_wdata;
        CFG_PRESS_HUM:  press_hum_r <= cfg_wdata[47:0];
        CFG_HUM:        hum_cal_r   <= cfg_wdata[31:0];
        default:        ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= PC_NONE;
      mph_r       <= 2'd0;
      ft_r        <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (out_valid_r && out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cmd_r   <= in_ch.cmd;
            raw_r   <= in_ch.raw_sample;
            pc_r    <= entry_pc(in_ch.cmd);
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (ui.op)
            OP_MUL: begin
              ma_r    <= va;
              mb_r    <= vb;
              mph_r   <= 2'd0;
              state_r <= ST_MUL;
            end
            OP_DIV: begin
              state_r <= ST_DIV;
            end
            OP_FTW: begin
              ft_r <= va[31:0];
              pc_r <= pc_r + 7'd1;
            end
            OP_CHKZ: begin
              if (va != 64'd0) begin
                pc_r <= pc_r + 7'd1;
              end else if (out_free) begin
                out_valid_r  <= 1'b1;
                out_kind_r   <= cmd_r;
                out_value_r  <= 33'sd0;
                out_status_r <= 1'b1;
                state_r      <= ST_IDLE;
              end
            end
            OP_OUT64, OP_OUT32, OP_OUTH: begin
              // hold until the output register is free
              if (out_free) begin
                out_valid_r  <= 1'b1;
                out_kind_r   <= cmd_r;
                out_status_r <= 1'b0;
                if (ui.op == OP_OUT32) begin
                  out_value_r <= {va[31], va[31:0]};
                end else if (ui.op == OP_OUTH) begin
                  out_value_r <= {13'd0, hclamp[31:12]};
                end else begin
                  out_value_r <= va[32:0];
                end
                state_r <= ST_IDLE;
              end
            end
            default: begin
              rf_r[ui.dst] <= alu_res;
              pc_r         <= pc_r + 7'd1;
            end
          endcase
        end
        ST_MUL: begin
          prod_r <= mul_x * mul_y;
          mph_r  <= mph_r + 2'd1;
          case (mph_r)
            2'd0:    ;
            2'd1:    acc_r <= prod_r;
            2'd2:    acc_r <= acc_r + {prod_r[31:0], 32'd0};
            default: begin
              rf_r[ui.dst] <= acc_r + {prod_r[31:0], 32'd0};
              pc_r         <= pc_r + 7'd1;
              state_r      <= ST_EXEC;
            end
          endcase
        end
        ST_DIV: begin
          if (div_done) begin
            rf_r[ui.dst] <= div_q;
            pc_r         <= pc_r + 7'd1;
            state_r      <= ST_EXEC;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.kind   = out_kind_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;

  // Divisor-zero flag only on pressure results, with a zero value
  a_status_press: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_kind_r == CMD_PRESS && out_value_r == 33'sd0))
    else $error("status set on a result that is not a zero pressure");

  // Humidity never exceeds 100 % in Q22.10
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == CMD_HUM) |-> (out_value_r[32:20] == 13'd0 &&
      out_value_r[19:0] <= HUM_MAX[31:12]))
    else $error("humidity result out of range");

  // An accepted item keeps the sequencer busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input taken again before the item was worked");

  // The divider finishes only while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider result with no waiting sequencer");

endmodule

>>> hw/rtl/esc_div.sv
module esc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [63:0] quo_r;
  logic [63:0] rem_r;
  logic [63:0] den_r;
  logic [6:0]  cnt_r;
  logic        neg_r;
  logic        done_r;
  logic [65:0] trial;

  // Trial subtract of the shifted remainder
  assign trial = {1'b0, rem_r, quo_r[63]} - {2'b00, den_r};

  // One quotient bit per cycle, magnitudes only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 7'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= 7'd64;
        neg_r <= num[63] ^ den[63];
        quo_r <= num[63] ? (~num + 64'd1) : num;
        den_r <= den[63] ? (~den + 64'd1) : den;
        rem_r <= 64'd0;
      end else if (cnt_r != 7'd0) begin
        cnt_r <= cnt_r - 7'd1;
        if (trial[65]) begin
          rem_r <= {rem_r[62:0], quo_r[63]};
        end else begin
          rem_r <= trial[63:0];
        end
        quo_r <= {quo_r[62:0], ~trial[65]};
        if (cnt_r == 7'd1) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Restore the sign, truncating toward zero
  assign done = done_r;
  assign quo  = neg_r ? (~quo_r + 64'd1) : quo_r;

endmodule

>>> test/env_sensor_compensation_checker.sv
`timescale 1ns / 100ps

module env_sensor_compensation_checker (
  input  logic        clk,
  input  logic        rst_n,
  esc_in_if           in_ch,
  esc_out_if          out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  import esc_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [32:0] value;
    logic        status;
  } comp_result_t;

  logic [47:0] temp_cal_q;
  logic [63:0] press_lo_q, press_hi_q;
  logic [47:0] press_hum_q;
  logic [31:0] hum_cal_q;
  logic [31:0] fine_temp_q;
  comp_result_t sample_queue[$];

  assign pending = sample_queue.size();

  // Temperature: updates the fine term, returns 0.01 degC
  function automatic logic [32:0] comp_temp(logic [19:0] adc, output logic [31:0] ft);
    logic signed [31:0] t1, t2, t3, a, b, v1, v2, t;
    t1 = {16'd0, temp_cal_q[15:0]};
    t2 = {{16{temp_cal_q[31]}}, temp_cal_q[31:16]};
    t3 = {{16{temp_cal_q[47]}}, temp_cal_q[47:32]};
    a  = {15'd0, adc[19:3]} - (t1 << 1);
    v1 = (a * t2) >>> 11;
    b  = {16'd0, adc[19:4]} - t1;
    v2 = (((b * b) >>> 12) * t3) >>> 14;
    ft = v1 + v2;
    t  = ($signed(ft) * 32'sd5 + 32'sd128) >>> 8;
    return {t[31], t};
  endfunction

  // Pressure: Pa in Q24.8; zero divisor flagged
  function automatic logic [32:0] comp_press(logic [19:0] adc, output logic err);
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] v1, v2, p, q, num, ua, ub, uq;
    p1 = {48'd0, press_lo_q[15:0]};
    p2 = {{48{press_lo_q[31]}}, press_lo_q[31:16]};
    p3 = {{48{press_lo_q[47]}}, press_lo_q[47:32]};
    p4 = {{48{press_lo_q[63]}}, press_lo_q[63:48]};
    p5 = {{48{press_hi_q[15]}}, press_hi_q[15:0]};
    p6 = {{48{press_hi_q[31]}}, press_hi_q[31:16]};
    p7 = {{48{press_hi_q[47]}}, press_hi_q[47:32]};
    p8 = {{48{press_hi_q[63]}}, press_hi_q[63:48]};
    p9 = {{48{press_hum_q[15]}}, press_hum_q[15:0]};
    v1 = {{32{fine_temp_q[31]}}, fine_temp_q} - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) << 12);
    v1 = (((64'sd1 << 47) + v1) * p1) >>> 33;
    err = 1'b0;
    if (v1 == 0) begin
      err = 1'b1;
      return '0;
    end
    p   = 64'sd1048576 - {44'd0, adc};
    num = ((p << 31) - v2) * 64'sd3125;
    // truncate toward zero on magnitudes
    ua  = num[63] ? -num : num;
    ub  = v1[63] ? -v1 : v1;
    uq  = $unsigned(ua) / $unsigned(ub);
    p   = (num[63] != v1[63]) ? -uq : uq;
    q   = p >>> 13;
    v1  = (p9 * q * q) >>> 25;
    v2  = (p8 * p) >>> 19;
    p   = ((p + v1 + v2) >>> 8) + (p7 << 4);
    return p[32:0];
  endfunction

  // Humidity: percent in Q22.10, clamped
  function automatic logic [32:0] comp_hum(logic [15:0] raw);
    logic signed [31:0] h1, h2, h3, h4, h5, h6, x, a, b, s;
    h1 = {24'd0, press_hum_q[23:16]};
    h2 = {{16{press_hum_q[39]}}, press_hum_q[39:24]};
    h3 = {24'd0, press_hum_q[47:40]};
    h4 = {{20{hum_cal_q[11]}}, hum_cal_q[11:0]};
    h5 = {{20{hum_cal_q[23]}}, hum_cal_q[23:12]};
    h6 = {{24{hum_cal_q[31]}}, hum_cal_q[31:24]};
    x  = fine_temp_q - 32'sd76800;
    a  = ({16'd0, raw} << 14) - (h4 << 20) - h5 * x + 32'sd16384;
    a  = a >>> 15;
    b  = ((x * h6) >>> 10) * (((x * h3) >>> 11) + 32'sd32768);
    b  = (b >>> 10) + 32'sd2097152;
    b  = (b * h2 + 32'sd8192) >>> 14;
    x  = a * b;
    s  = x >>> 15;
    x  = x - ((((s * s) >>> 7) * h1) >>> 4);
    if (x < 0) x = 0;
    if ($unsigned(x) > HUM_MAX) x = HUM_MAX;
    return {13'd0, x[31:12]};
  endfunction

  // Track calibration writes and predict on each accepted sample beat
  always @(posedge clk) begin
    comp_result_t r;
    logic [31:0] ft;
    logic err;
    if (!rst_n) begin
      temp_cal_q  <= '0;
      press_lo_q  <= '0;
      press_hi_q  <= '0;
      press_hum_q <= '0;
      hum_cal_q   <= '0;
      fine_temp_q <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_TEMP:       temp_cal_q  <= cfg_wdata[47:0];
          CFG_PRESS_LOW:  press_lo_q  <= cfg_wdata;
          CFG_PRESS_HIGH: press_hi_q  <= cfg_wdata;
          CFG_PRESS_HUM:  press_hum_q <= cfg_wdata[47:0];
          CFG_HUM:        hum_cal_q   <= cfg_wdata[31:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        r.kind = in_ch.cmd;
        r.value = '0;
        r.status = 1'b0;
        case (in_ch.cmd)
          CMD_TEMP: begin
            r.value = comp_temp(in_ch.raw_sample, ft);
            fine_temp_q <= ft;
          end
          CMD_PRESS: begin
            r.value = comp_press(in_ch.raw_sample, err);
            r.status = err;
          end
          CMD_HUM: r.value = comp_hum(in_ch.raw_sample[15:0]);
          default: ;
        endcase
        sample_queue.push_back(r);
      end
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    comp_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sample_queue.size() == 0) begin
        $error("result beat with nothing expected: kind %0d", out_ch.kind);
        fail_count++;
      end else begin
        e = sample_queue.pop_front();
        if (out_ch.kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_ch.kind);
          fail_count++;
        end
        if (out_ch.value !== e.value) begin
          $error("value: expected %h, got %h", e.value, out_ch.value);
          fail_count++;
        end
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_ch.status);
          fail_count++;
        end
      end
    end
  end
endmodule

>>> test/env_sensor_compensation_unit_tb.sv
`timescale 1ns / 100ps

module env_sensor_compensation_unit_tb;
  import esc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_t    cfg_addr;
  logic [63:0] cfg_wdata;
  logic        idle_enable;
  int          fail_count;
  int          pending;
  int          cycle_count;

  esc_in_if  in_ch ();
  esc_out_if out_ch ();

  env_sensor_compensation_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  env_sensor_compensation_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result sink: ready with random stall bursts
  always @(posedge clk) begin
    int stall;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 3) == 0) begin
      stall = $urandom_range(1, 12);
      out_ch.ready <= 1'b0;
      repeat (stall) @(posedge clk);
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Drive one sample beat, hold until accepted, maybe idle afterwards
  task automatic send_sample(logic [1:0] cmd, logic [19:0] raw);
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.raw_sample <= raw;
    do @(posedge clk); while (!in_ch.ready);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Plausible calibration set near typical factory values, with random spread
  task automatic load_typical_cal();
    write_reg(CFG_TEMP, 64'({16'($signed(-16'sd1000 + $urandom_range(0, 20))),
                             16'(26000 + $urandom_range(0, 1000)),
                             16'(27000 + $urandom_range(0, 2000))}));
    write_reg(CFG_PRESS_LOW, {16'(2800 + $urandom_range(0, 500)),
                              16'(3024), 16'(-10600 + $urandom_range(0, 300)),
                              16'(36000 + $urandom_range(0, 2000))});
    write_reg(CFG_PRESS_HIGH, {16'(-16'sd12000 + $urandom_range(0, 400)),
                               16'(15500), 16'(-7), 16'(140 + $urandom_range(0, 60))});
    write_reg(CFG_PRESS_HUM, 64'({8'd0, 16'(350 + $urandom_range(0, 60)),
                                  8'd75, 16'(6000)}));
    write_reg(CFG_HUM, 64'({8'd30, 12'd50, 12'(300 + $urandom_range(0, 40))}));
  endtask

  task automatic load_random_cal();
    write_reg(CFG_TEMP, {$urandom, $urandom});
    write_reg(CFG_PRESS_LOW, {$urandom, $urandom});
    write_reg(CFG_PRESS_HIGH, {$urandom, $urandom});
    write_reg(CFG_PRESS_HUM, {$urandom, $urandom});
    write_reg(CFG_HUM, {$urandom, $urandom});
  endtask

  task automatic run_random(int count);
    logic [1:0] cmd;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0) cmd = CMD_NONE;
      else cmd = 2'($urandom_range(0, 2));
      // sometimes a temperature first so the fine term stays realistic
      if ($urandom_range(0, 3) == 0) send_sample(CMD_TEMP, 20'($urandom));
      send_sample(cmd, 20'($urandom));
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_addr         = CFG_TEMP;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_TEMP;
    in_ch.raw_sample = '0;
    idle_enable      = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset calibration: pressure divisor is zero
    send_sample(CMD_TEMP, 20'd0);
    send_sample(CMD_PRESS, 20'hFFFFF);
    send_sample(CMD_HUM, 20'd0);
    send_sample(CMD_NONE, 20'h5A5A5);
    drain();

    // Typical calibration: extremes of the raw reading per kind
    load_typical_cal();
    send_sample(CMD_TEMP, 20'h80000);
    send_sample(CMD_PRESS, 20'h60000);
    send_sample(CMD_HUM, 20'h06A00);
    send_sample(CMD_TEMP, 20'hFFFFF);
    send_sample(CMD_PRESS, 20'd0);
    send_sample(CMD_HUM, 20'hFFFFF);
    send_sample(CMD_HUM, 20'd0);
    send_sample(CMD_TEMP, 20'd0);
    send_sample(CMD_PRESS, 20'hFFFFF);
    send_sample(CMD_NONE, 20'hFFFFF);
    send_sample(CMD_HUM, 20'h0FFFF);
    drain();

    // All-ones calibration extremes
    write_reg(CFG_TEMP, '1);
    write_reg(CFG_PRESS_LOW, '1);
    write_reg(CFG_PRESS_HIGH, '1);
    write_reg(CFG_PRESS_HUM, '1);
    write_reg(CFG_HUM, '1);
    send_sample(CMD_TEMP, 20'hABCDE);
    send_sample(CMD_PRESS, 20'h12345);
    send_sample(CMD_HUM, 20'h8000);
    drain();

    // Random phases alternating realistic and arbitrary calibration
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 2 == 0) load_typical_cal();
      else load_random_cal();
      run_random(45);
      drain();
    end

    // Final stretch at full rate
    idle_enable = 1'b0;
    load_typical_cal();
    run_random(60);
    drain();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/esc_pkg.sv
hw/rtl/esc_if.sv
hw/rtl/esc_div.sv
hw/rtl/env_sensor_compensation_unit.sv
test/env_sensor_compensation_checker.sv
test/env_sensor_compensation_unit_tb.sv
